// ===== design/gsff_pkg.sv =====
`default_nettype none
package gsff_pkg;

  // Fixed data format: signed Q4.12 values.
  localparam int DATA_BITS    = 16;
  localparam int FRAC_BITS    = DATA_BITS - 4;
  localparam int GSUM_BITS    = 40;
  localparam int ACT_BITS     = 24;
  localparam int ACTV_BITS    = 32;
  localparam int OSUM_BITS    = 48;
  localparam int SIG_ENTRIES  = 256;
  localparam int SIG_BITS     = 17;
  localparam int SIG_ONE      = 65536;

  // Default capacities and register reset values.
  localparam int DEF_MAX_RECORDS = 64;
  localparam int DEF_MAX_WIDTH   = 128;
  localparam int RECORDS_RESET   = 64;
  localparam int WIDTH_RESET     = 128;

  // Configuration register indexes.
  localparam logic CFG_RECORDS = 1'b0;
  localparam logic CFG_WIDTH   = 1'b1;

  typedef enum logic [2:0] {
    CMD_GATE   = 3'd0,
    CMD_UP     = 3'd1,
    CMD_DOWN   = 3'd2,
    CMD_HIDDEN = 3'd3,
    CMD_RUN    = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_DOT,
    S_DOT_WAIT,
    S_ACT1,
    S_ACT2,
    S_ACT3,
    S_ACT4,
    S_ACT5,
    S_DOWN,
    S_DOWN_WAIT
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         record_index;
    logic [6:0]         coordinate_index;
    logic signed [15:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         out_coordinate;
    logic signed [15:0] out_value;
    logic               saturated_flag;
  } out_item_t;

  typedef logic [SIG_BITS-1:0] sig_tab_t [SIG_ENTRIES];

  // Division by the small series index, one constant divisor per arm.
  function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
    logic [63:0] r;
    unique case (k)
      1:       r = v;
      2:       r = v / 64'd2;
      3:       r = v / 64'd3;
      4:       r = v / 64'd4;
      5:       r = v / 64'd5;
      6:       r = v / 64'd6;
      7:       r = v / 64'd7;
      8:       r = v / 64'd8;
      9:       r = v / 64'd9;
      10:      r = v / 64'd10;
      11:      r = v / 64'd11;
      12:      r = v / 64'd12;
      13:      r = v / 64'd13;
      default: r = v / 64'd14;
    endcase
    return r;
  endfunction

  // Unsigned quotient by restoring long division, used only for the table.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-x) in Q.31 by a series on x/16, then squared four times.
  function automatic logic [63:0] exp_neg(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    y    = x >> 4;
    term = 64'd1 << 31;
    pos  = 64'd1 << 31;
    neg  = 64'd0;
    for (int k = 1; k <= 14; k++) begin
      term = div_small((term * y) >> 31, k);
      if ((k % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    for (int n = 0; n < 4; n++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    return e;
  endfunction

  // Sigmoid points over |x| in [0, 8), Q0.16.
  function automatic sig_tab_t build_sig();
    sig_tab_t    t;
    logic [63:0] x;
    logic [63:0] den;
    logic [63:0] v;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      x    = (64'(i) << 34) / SIG_ENTRIES;
      den  = (64'd1 << 31) + exp_neg(x);
      v    = div_u64((64'd1 << 47) + (den >> 1), den);
      t[i] = v[SIG_BITS-1:0];
    end
    return t;
  endfunction

  localparam sig_tab_t SigTable = build_sig();

endpackage
`default_nettype wire

// ===== design/gated_silu_feedforward.sv =====
// Gated SiLU feed-forward layer.
// Input channel (in_valid_i/in_ready_o, in_item_i) carries commands: gate, up
// and down weight loads, hidden element loads, run and read output. Output
// channel (out_valid_o/out_ready_i, out_item_o) returns one element per read.
// Back-to-back loads transfer every cycle while the block is idle.
// A read passes through the read state and presents its result in an output
// register; the next load or run can transfer while that result waits.
// A run first clears the output accumulators in a pass over MAX_WIDTH entries,
// then per record walks the weight memories: nw coordinates for the gate and up
// dot products, a five step activation sequence, and nw coordinates for the down
// row read-modify-write of the output memory, plus a pipeline drain after each
// walk. A run with zero records or zero width ends after the clear pass.
// The single read port of each weight memory sets the pace of each walk.
// Reset restores records_in_use to 64 and width_in_use to 128 and marks the
// outputs as zero until the first run; weights and hidden must be loaded.
// A read stalls at the input while an earlier result has not been taken.
// Configuration writes (cfg_we_i) take effect at once and must come only
// while the block is idle.
`default_nettype none
module gated_silu_feedforward #(
  parameter int MAX_RECORDS = gsff_pkg::DEF_MAX_RECORDS,
  parameter int MAX_WIDTH   = gsff_pkg::DEF_MAX_WIDTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  gsff_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output gsff_pkg::out_item_t  out_item_o,
  input  wire                  cfg_we_i,
  input  wire                  cfg_index_i,
  input  wire [7:0]            cfg_data_i
);
  import gsff_pkg::*;

  localparam int Depth = MAX_RECORDS * MAX_WIDTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int NrW   = $clog2(MAX_RECORDS + 1);
  localparam int NwW   = $clog2(MAX_WIDTH + 1);
  localparam int SigW  = $clog2(SIG_ENTRIES);
  localparam int SigSh = SigW - 3;

  localparam logic signed [GSUM_BITS-1:0] GsMax = {1'b0, {(GSUM_BITS-1){1'b1}}};
  localparam logic signed [GSUM_BITS-1:0] GsMin = {1'b1, {(GSUM_BITS-1){1'b0}}};
  localparam logic signed [OSUM_BITS-1:0] OsMax = {1'b0, {(OSUM_BITS-1){1'b1}}};
  localparam logic signed [OSUM_BITS-1:0] OsMin = {1'b1, {(OSUM_BITS-1){1'b0}}};
  localparam logic signed [ACT_BITS-1:0]  AqMax = {1'b0, {(ACT_BITS-1){1'b1}}};
  localparam logic signed [ACT_BITS-1:0]  AqMin = {1'b1, {(ACT_BITS-1){1'b0}}};
  localparam logic signed [ACTV_BITS-1:0] AvMax = {1'b0, {(ACTV_BITS-1){1'b1}}};
  localparam logic signed [ACTV_BITS-1:0] AvMin = {1'b1, {(ACTV_BITS-1){1'b0}}};
  localparam logic signed [DATA_BITS-1:0] DMax  = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] DMin  = {1'b1, {(DATA_BITS-1){1'b0}}};

  // Saturating accumulator add for the dot products.
  function automatic logic signed [GSUM_BITS-1:0] sat_gs(input logic signed [GSUM_BITS:0] v);
    logic signed [GSUM_BITS-1:0] r;
    if (v > (GSUM_BITS+1)'(GsMax)) r = GsMax;
    else if (v < (GSUM_BITS+1)'(GsMin)) r = GsMin;
    else r = v[GSUM_BITS-1:0];
    return r;
  endfunction

  // Dot product rounded to Q.F and clipped to the activation width.
  function automatic logic signed [ACT_BITS-1:0] round_act(input logic signed [GSUM_BITS-1:0] v);
    logic signed [GSUM_BITS:0] w;
    logic signed [GSUM_BITS-FRAC_BITS:0] s;
    logic signed [ACT_BITS-1:0] r;
    w = (GSUM_BITS+1)'(v) + (GSUM_BITS+1)'(1 << (FRAC_BITS - 1));
    s = w[GSUM_BITS:FRAC_BITS];
    if (s > (GSUM_BITS-FRAC_BITS+1)'(AqMax)) r = AqMax;
    else if (s < (GSUM_BITS-FRAC_BITS+1)'(AqMin)) r = AqMin;
    else r = s[ACT_BITS-1:0];
    return r;
  endfunction

  // Configuration registers.
  logic [6:0] records_q;
  logic [7:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      records_q <= 7'(RECORDS_RESET);
      width_q   <= 8'(WIDTH_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RECORDS: records_q <= cfg_data_i[6:0];
        CFG_WIDTH:   width_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Effective counts, limited to the capacity.
  logic [NrW-1:0] nr;
  logic [NwW-1:0] nw;

  always_comb begin
    if (32'(records_q) > MAX_RECORDS) nr = NrW'(MAX_RECORDS);
    else nr = NrW'(records_q);
    if (32'(width_q) > MAX_WIDTH) nw = NwW'(MAX_WIDTH);
    else nw = NwW'(width_q);
  end

  // Control registers.
  state_e         state_q, state_d;
  logic [CW-1:0]  crd_q;
  logic [NrW-1:0] rec_q;
  logic [AW-1:0]  base_q;
  logic           run_done_q;
  logic           v1_q, v2_q, d1_q, d2_q;
  logic           out_valid_q;

  logic           in_xfer;
  logic           dot_issue;
  logic           down_issue;
  logic           clear_we;
  logic           crd_last;
  logic           clr_last;
  logic           rec_last;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign crd_last = (NwW'(crd_q) + NwW'(1)) == nw;
  assign clr_last = 32'(crd_q) == (MAX_WIDTH - 1);
  assign rec_last = (rec_q + NrW'(1)) == nr;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && in_item_i.cmd == CMD_RUN) state_d = S_CLEAR;
        else if (in_xfer && in_item_i.cmd == CMD_READ) state_d = S_READ;
      end
      S_READ:  state_d = S_IDLE;
      S_CLEAR: begin
        if (clr_last) begin
          if (nr == '0 || nw == '0) state_d = S_IDLE;
          else state_d = S_DOT;
        end
      end
      S_DOT:      if (crd_last) state_d = S_DOT_WAIT;
      S_DOT_WAIT: if (!v1_q && !v2_q) state_d = S_ACT1;
      S_ACT1:     state_d = S_ACT2;
      S_ACT2:     state_d = S_ACT3;
      S_ACT3:     state_d = S_ACT4;
      S_ACT4:     state_d = S_ACT5;
      S_ACT5:     state_d = S_DOWN;
      S_DOWN:     if (crd_last) state_d = S_DOWN_WAIT;
      S_DOWN_WAIT: begin
        if (!d1_q && !d2_q) state_d = rec_last ? S_IDLE : S_DOT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    dot_issue  = 1'b0;
    down_issue = 1'b0;
    clear_we   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = !(out_valid_q && in_item_i.cmd == CMD_READ);
      S_CLEAR: clear_we   = 1'b1;
      S_DOT:   dot_issue  = 1'b1;
      S_DOWN:  down_issue = 1'b1;
      default: ;
    endcase
  end

  // Counters and pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      crd_q      <= '0;
      rec_q      <= '0;
      base_q     <= '0;
      run_done_q <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      d1_q       <= 1'b0;
      d2_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= dot_issue;
      v2_q    <= v1_q;
      d1_q    <= down_issue;
      d2_q    <= d1_q;
      if (state_d != state_q) crd_q <= '0;
      else if (dot_issue || down_issue || clear_we) crd_q <= crd_q + CW'(1);
      if (in_xfer && in_item_i.cmd == CMD_RUN) begin
        rec_q      <= '0;
        base_q     <= '0;
        run_done_q <= 1'b1;
      end else if (state_q == S_DOWN_WAIT && state_d == S_DOT) begin
        rec_q  <= rec_q + NrW'(1);
        base_q <= base_q + AW'(MAX_WIDTH);
      end
    end
  end

  // Weight and hidden memories.
  logic signed [DATA_BITS-1:0] gate_mem [Depth];
  logic signed [DATA_BITS-1:0] up_mem   [Depth];
  logic signed [DATA_BITS-1:0] down_mem [Depth];
  logic signed [DATA_BITS-1:0] hid_mem  [MAX_WIDTH];
  logic signed [DATA_BITS-1:0] g_rd_q, u_rd_q, dn_rd_q, h_rd_q;

  logic          wr_rec_ok, wr_crd_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_rec_ok = 32'(in_item_i.record_index) < MAX_RECORDS;
  assign wr_crd_ok = 32'(in_item_i.coordinate_index) < MAX_WIDTH;
  assign wr_addr   = AW'(AW'(in_item_i.record_index) * AW'(MAX_WIDTH))
                     + AW'(in_item_i.coordinate_index);
  assign rd_addr   = base_q + AW'(crd_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer && wr_rec_ok && wr_crd_ok) begin
      if (in_item_i.cmd == CMD_GATE) gate_mem[wr_addr] <= in_item_i.data_value;
      if (in_item_i.cmd == CMD_UP)   up_mem[wr_addr]   <= in_item_i.data_value;
      if (in_item_i.cmd == CMD_DOWN) down_mem[wr_addr] <= in_item_i.data_value;
    end
    if (in_xfer && wr_crd_ok && in_item_i.cmd == CMD_HIDDEN) begin
      hid_mem[CW'(in_item_i.coordinate_index)] <= in_item_i.data_value;
    end
    g_rd_q  <= gate_mem[rd_addr];
    u_rd_q  <= up_mem[rd_addr];
    dn_rd_q <= down_mem[rd_addr];
    h_rd_q  <= hid_mem[crd_q];
  end

  // Output accumulator memory: cleared by a run, read-modify-write during the down pass.
  logic signed [OSUM_BITS-1:0] osum_mem [MAX_WIDTH];
  logic signed [OSUM_BITS-1:0] os_rd_q;
  logic [CW-1:0]               os_raddr;
  logic [CW-1:0]               a1_q, a2_q;
  logic signed [OSUM_BITS-1:0] os2_q;
  logic signed [OSUM_BITS-1:0] pd_q;
  logic signed [OSUM_BITS:0]   os_sum;
  logic signed [OSUM_BITS-1:0] os_new;

  assign os_raddr = (state_q == S_IDLE) ? CW'(in_item_i.coordinate_index) : crd_q;
  assign os_sum   = (OSUM_BITS+1)'(os2_q) + (OSUM_BITS+1)'(pd_q);

  always_comb begin
    if (os_sum > (OSUM_BITS+1)'(OsMax)) os_new = OsMax;
    else if (os_sum < (OSUM_BITS+1)'(OsMin)) os_new = OsMin;
    else os_new = os_sum[OSUM_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (clear_we) osum_mem[crd_q] <= '0;
    else if (d2_q) osum_mem[a2_q] <= os_new;
    os_rd_q <= osum_mem[os_raddr];
  end

  // Dot product pipeline: products, then saturating accumulation.
  logic signed [2*DATA_BITS-1:0] pg_q, pu_q;
  logic signed [GSUM_BITS-1:0]   gs_q, us_q;
  logic                          dot_start;

  assign dot_start = (state_d == S_DOT) && (state_q != S_DOT);

  always_ff @(posedge clk_i) begin
    pg_q <= h_rd_q * g_rd_q;
    pu_q <= h_rd_q * u_rd_q;
    if (dot_start) begin
      gs_q <= '0;
      us_q <= '0;
    end else if (v2_q) begin
      gs_q <= sat_gs((GSUM_BITS+1)'(gs_q) + (GSUM_BITS+1)'(pg_q));
      us_q <= sat_gs((GSUM_BITS+1)'(us_q) + (GSUM_BITS+1)'(pu_q));
    end
  end

  // Activation sequence: round, sigmoid lookup, silu, gate by up, round.
  logic signed [ACT_BITS-1:0]      gq_q, uq_q;
  logic [SIG_BITS-1:0]             sig_q;
  logic signed [ACT_BITS+1:0]      silu_q;
  logic signed [2*ACT_BITS+1:0]    m_q;
  logic signed [ACTV_BITS-1:0]     act_q;

  logic [ACT_BITS-1:0]             a_abs;
  logic [31:0]                     p_pos;
  logic [SigW-1:0]                 s_idx;
  logic [FRAC_BITS-1:0]            s_frac;
  logic [SIG_BITS-1:0]             s_lo, s_hi;
  logic [SIG_BITS+FRAC_BITS-1:0]   s_step;
  logic [SIG_BITS-1:0]             s_val;
  logic signed [ACT_BITS+SIG_BITS:0] silu_p;
  logic signed [ACT_BITS+SIG_BITS+1:0] silu_r;
  logic signed [2*ACT_BITS+2:0]    m_r;
  logic signed [2*ACT_BITS+2-FRAC_BITS:0] m_s;
  logic signed [ACTV_BITS-1:0]     act_d;

  always_comb begin
    a_abs  = gq_q[ACT_BITS-1] ? ACT_BITS'(-gq_q) : ACT_BITS'(gq_q);
    p_pos  = 32'(a_abs) << SigSh;
    s_idx  = p_pos[FRAC_BITS+SigW-1:FRAC_BITS];
    s_frac = p_pos[FRAC_BITS-1:0];
    s_lo   = SigTable[s_idx];
    s_hi   = (32'(s_idx) == SIG_ENTRIES - 1) ? SIG_BITS'(SIG_ONE)
                                             : SigTable[s_idx + SigW'(1)];
    s_step = (SIG_BITS+FRAC_BITS)'(s_hi - s_lo) * (SIG_BITS+FRAC_BITS)'(s_frac);
    if (32'(a_abs) >= (8 << FRAC_BITS)) s_val = SIG_BITS'(SIG_ONE);
    else s_val = s_lo + SIG_BITS'(s_step >> FRAC_BITS);
    if (gq_q[ACT_BITS-1]) s_val = SIG_BITS'(SIG_ONE) - s_val;

    silu_p = gq_q * $signed({1'b0, sig_q});
    silu_r = (ACT_BITS+SIG_BITS+2)'(silu_p) + (ACT_BITS+SIG_BITS+2)'(1 << 15);

    m_r = (2*ACT_BITS+3)'(m_q) + (2*ACT_BITS+3)'(1 << (FRAC_BITS - 1));
    m_s = m_r[2*ACT_BITS+2:FRAC_BITS];
    if (m_s > (2*ACT_BITS+3-FRAC_BITS)'(AvMax)) act_d = AvMax;
    else if (m_s < (2*ACT_BITS+3-FRAC_BITS)'(AvMin)) act_d = AvMin;
    else act_d = m_s[ACTV_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ACT1) begin
      gq_q <= round_act(gs_q);
      uq_q <= round_act(us_q);
    end
    if (state_q == S_ACT2) sig_q <= s_val;
    if (state_q == S_ACT3) silu_q <= silu_r[ACT_BITS+17:16];
    if (state_q == S_ACT4) m_q <= silu_q * uq_q;
    if (state_q == S_ACT5) act_q <= act_d;
  end

  // Down pass pipeline: product and old sum, then write back.
  always_ff @(posedge clk_i) begin
    a1_q  <= crd_q;
    a2_q  <= a1_q;
    pd_q  <= act_q * dn_rd_q;
    os2_q <= os_rd_q;
  end

  // Read result: round, saturate and hold in the output register.
  logic [6:0]                  rd_crd_q;
  logic                        rd_oob_q;
  logic signed [OSUM_BITS:0]   rd_w;
  logic signed [OSUM_BITS-FRAC_BITS:0] rd_s;
  logic signed [DATA_BITS-1:0] rd_val;
  logic                        rd_clip;
  out_item_t                   out_q;

  always_comb begin
    rd_w    = (OSUM_BITS+1)'(os_rd_q) + (OSUM_BITS+1)'(1 << (FRAC_BITS - 1));
    rd_s    = rd_w[OSUM_BITS:FRAC_BITS];
    rd_clip = 1'b0;
    if (rd_s > (OSUM_BITS-FRAC_BITS+1)'(DMax)) begin
      rd_val  = DMax;
      rd_clip = 1'b1;
    end else if (rd_s < (OSUM_BITS-FRAC_BITS+1)'(DMin)) begin
      rd_val  = DMin;
      rd_clip = 1'b1;
    end else begin
      rd_val = rd_s[DATA_BITS-1:0];
    end
    if (rd_oob_q || !run_done_q) begin
      rd_val  = '0;
      rd_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_crd_q <= in_item_i.coordinate_index;
      rd_oob_q <= !wr_crd_ok;
    end
    if (state_q == S_READ) begin
      out_q.out_coordinate <= rd_crd_q;
      out_q.out_value      <= rd_val;
      out_q.saturated_flag <= rd_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_READ) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A read transfer yields a valid result by way of the read state.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_item_i.cmd == CMD_READ) |=> ##1 out_valid_o)
    else $error("read transfer did not produce a result");

  // The dot product pipeline is empty when the activation starts.
  a_dot_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACT1) |-> (!v1_q && !v2_q))
    else $error("activation started before dot products drained");

  // No write-back of the down pass happens while idle or during the clearing pass.
  a_no_wb_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_q |-> (state_q != S_CLEAR && state_q != S_IDLE))
    else $error("output write-back outside a run");

endmodule
`default_nettype wire

// ===== tb/gated_silu_feedforward_tb.sv =====
`timescale 1ns / 1ps
module gated_silu_feedforward_tb;
  import gsff_pkg::*;

  localparam int NREC = DEF_MAX_RECORDS;
  localparam int NCRD = DEF_MAX_WIDTH;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = CFG_RECORDS;
  logic [7:0] cfg_data_i = 8'd0;

  gated_silu_feedforward dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the layer state.
  longint gate_w [NREC*NCRD];
  longint up_w [NREC*NCRD];
  longint down_w [NREC*NCRD];
  longint hidden_v [NCRD];
  longint out_acc [NCRD];
  bit gate_ok [NREC*NCRD];
  bit up_ok [NREC*NCRD];
  bit down_ok [NREC*NCRD];
  bit hidden_ok [NCRD];
  longint sig_pts [SIG_ENTRIES];
  int reg_records = RECORDS_RESET;
  int reg_width = WIDTH_RESET;

  out_item_t read_results [$];
  int errors = 0;
  int cycles = 0;
  bit in_idle_on = 1'b1;
  bit out_stall_on = 1'b1;

  // exp(-x) with x and result in Q.31.
  function automatic longint unsigned exp_series(input longint unsigned x);
    longint unsigned y, term, pos, neg, e;
    y = x >> 4;
    term = 64'd1 << 31;
    pos = term;
    neg = 0;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 31) / k;
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    e = (pos > neg) ? pos - neg : 0;
    for (int n = 0; n < 4; n++) e = (e * e + (64'd1 << 30)) >> 31;
    return e;
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_to(input longint v, input int bits, inout bit hit);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint silu_q(input longint x);
    longint a, p, idx, frac, lo, hi, s;
    a = (x < 0) ? -x : x;
    if (a >= (64'sd8 <<< FRAC_BITS)) begin
      s = SIG_ONE;
    end else begin
      p = (a * SIG_ENTRIES) >>> 3;
      idx = p >>> FRAC_BITS;
      frac = p & ((64'sd1 <<< FRAC_BITS) - 1);
      if (idx >= SIG_ENTRIES) idx = SIG_ENTRIES - 1;
      lo = sig_pts[idx];
      hi = (idx + 1 < SIG_ENTRIES) ? sig_pts[idx + 1] : SIG_ONE;
      s = lo + (((hi - lo) * frac) >>> FRAC_BITS);
    end
    if (x < 0) s = SIG_ONE - s;
    return rnd_shift(x * s, 16);
  endfunction

  function automatic int eff_records();
    return (reg_records < NREC) ? reg_records : NREC;
  endfunction

  function automatic int eff_width();
    return (reg_width < NCRD) ? reg_width : NCRD;
  endfunction

  // Whole-layer evaluation into the output accumulators.
  task automatic compute_layer();
    longint gs, us, gq, uq, act;
    bit hit;
    int nr, nw;
    nr = eff_records();
    nw = eff_width();
    hit = 1'b0;
    foreach (out_acc[c]) out_acc[c] = 0;
    for (int r = 0; r < nr; r++) begin
      gs = 0;
      us = 0;
      for (int c = 0; c < nw; c++) begin
        gs = clip_to(gs + hidden_v[c] * gate_w[r*NCRD + c], GSUM_BITS, hit);
        us = clip_to(us + hidden_v[c] * up_w[r*NCRD + c], GSUM_BITS, hit);
      end
      gq = clip_to(rnd_shift(gs, FRAC_BITS), ACT_BITS, hit);
      uq = clip_to(rnd_shift(us, FRAC_BITS), ACT_BITS, hit);
      act = clip_to(rnd_shift(silu_q(gq) * uq, FRAC_BITS), ACTV_BITS, hit);
      for (int c = 0; c < nw; c++)
        out_acc[c] = clip_to(out_acc[c] + act * down_w[r*NCRD + c], OSUM_BITS, hit);
    end
  endtask

  // Update the shadow state for one accepted command.
  task automatic apply_command(input in_item_t it);
    int a;
    longint d;
    bit hit;
    out_item_t res;
    a = it.record_index * NCRD + it.coordinate_index;
    d = longint'($signed(it.data_value));
    case (it.cmd)
      CMD_GATE: begin
        gate_w[a] = d;
        gate_ok[a] = 1'b1;
      end
      CMD_UP: begin
        up_w[a] = d;
        up_ok[a] = 1'b1;
      end
      CMD_DOWN: begin
        down_w[a] = d;
        down_ok[a] = 1'b1;
      end
      CMD_HIDDEN: begin
        hidden_v[it.coordinate_index] = d;
        hidden_ok[it.coordinate_index] = 1'b1;
      end
      CMD_RUN: compute_layer();
      CMD_READ: begin
        hit = 1'b0;
        d = clip_to(rnd_shift(out_acc[it.coordinate_index], FRAC_BITS), DATA_BITS, hit);
        res.out_coordinate = it.coordinate_index;
        res.out_value = d[15:0];
        res.saturated_flag = hit;
        read_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Drive one command and wait for its transfer.
  task automatic send_item(input in_item_t it);
    int gap;
    bit taken;
    gap = in_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    // Ready only changes at rising edges, so it is sampled in mid cycle.
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    apply_command(it);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input int rec, input int crd,
                          input logic [15:0] val);
    in_item_t it;
    it.cmd = cmd;
    it.record_index = rec[5:0];
    it.coordinate_index = crd[6:0];
    it.data_value = val;
    send_item(it);
  endtask

  function automatic logic [15:0] rand_data();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8192) - 4096);
  endfunction

  // Load every entry a run will touch that has not been written yet.
  task automatic load_missing();
    int nr, nw;
    nr = eff_records();
    nw = eff_width();
    for (int c = 0; c < nw; c++)
      if (!hidden_ok[c]) send_cmd(CMD_HIDDEN, 0, c, rand_data());
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nw; c++) begin
        if (!gate_ok[r*NCRD + c]) send_cmd(CMD_GATE, r, c, rand_data());
        if (!up_ok[r*NCRD + c]) send_cmd(CMD_UP, r, c, rand_data());
        if (!down_ok[r*NCRD + c]) send_cmd(CMD_DOWN, r, c, rand_data());
      end
  endtask

  task automatic run_layer_cmd();
    load_missing();
    send_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 127), 16'($urandom));
  endtask

  task automatic read_out(input int crd);
    send_cmd(CMD_READ, $urandom_range(0, 63), crd, 16'($urandom));
  endtask

  // Wait until all reads are back and any run has surely finished.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (read_results.size() != 0) @(posedge clk_i);
    repeat (2 * (NCRD + eff_records() * (2 * eff_width() + 11)) + 100) @(posedge clk_i);
  endtask

  task automatic set_layer(input int nr, input int nw);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_RECORDS;
    cfg_data_i <= 8'(nr);
    @(posedge clk_i);
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i <= 8'(nw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_records = nr & 8'h7F;
    reg_width = nw & 8'hFF;
  endtask

  // Reads before any run return zero.
  task automatic test_reads_after_reset();
    read_out(0);
    read_out(NCRD - 1);
    read_out($urandom_range(0, 127));
  endtask

  // Single-element layers with extreme values, empty layers, unused codes.
  task automatic test_extremes();
    set_layer(1, 1);
    send_cmd(CMD_HIDDEN, 0, 0, 16'h7FFF);
    send_cmd(CMD_GATE, 0, 0, 16'h7FFF);
    send_cmd(CMD_UP, 0, 0, 16'h7FFF);
    send_cmd(CMD_DOWN, 0, 0, 16'h7FFF);
    run_layer_cmd();
    read_out(0);
    read_out(1);
    send_cmd(CMD_DOWN, 0, 0, 16'h8000);
    run_layer_cmd();
    read_out(0);
    send_cmd(CMD_GATE, 0, 0, 16'h8000);
    send_cmd(CMD_HIDDEN, 0, 0, 16'h8000);
    run_layer_cmd();
    read_out(0);
    send_cmd(CMD_UP, 0, 0, 16'h0000);
    run_layer_cmd();
    read_out(0);
    // Unused command codes are ignored.
    send_cmd(3'd6, 63, 127, 16'hFFFF);
    send_cmd(3'd7, 0, 0, 16'h0000);
    // Zero records or zero width leave the outputs at zero.
    set_layer(0, 8);
    run_layer_cmd();
    read_out(0);
    set_layer(4, 0);
    run_layer_cmd();
    read_out(3);
  endtask

  // Registers past capacity clamp to the full record count or width; counts at capacity run too.
  task automatic test_full_layer();
    bit saved;
    saved = in_idle_on;
    // Every record over a single coordinate.
    in_idle_on = 1'b0;
    set_layer(127, 1);
    run_layer_cmd();
    in_idle_on = saved;
    read_out(0);
    read_out(NCRD - 1);
    // One record over every coordinate.
    in_idle_on = 1'b0;
    set_layer(1, 255);
    run_layer_cmd();
    in_idle_on = saved;
    read_out(0);
    read_out(NCRD - 1);
    read_out($urandom_range(0, 127));
    // Counts exactly at capacity.
    set_layer(NREC, 1);
    send_cmd(CMD_HIDDEN, 0, 0, rand_data());
    run_layer_cmd();
    read_out(0);
    set_layer(1, NCRD);
    send_cmd(CMD_HIDDEN, 0, 5, rand_data());
    run_layer_cmd();
    read_out(5);
    read_out($urandom_range(0, 127));
  endtask

  // Phases of random loads, runs and reads on small layers.
  task automatic test_random(input int total);
    int sent, pick, nr, nw;
    sent = 0;
    while (sent < total) begin
      nr = $urandom_range(1, 8);
      nw = $urandom_range(1, 16);
      set_layer(nr, nw);
      in_idle_on = $urandom_range(0, 3) != 0;
      out_stall_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 100 && sent < total; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_cmd(3'($urandom_range(0, 3)),
                   ($urandom_range(0, 3) != 0) ? $urandom_range(0, nr - 1)
                                               : $urandom_range(0, 63),
                   ($urandom_range(0, 3) != 0) ? $urandom_range(0, nw - 1)
                                               : $urandom_range(0, 127),
                   rand_data());
          sent++;
        end else if (pick < 65) begin
          run_layer_cmd();
          sent++;
        end else if (pick < 97) begin
          read_out(($urandom_range(0, 7) != 0) ? $urandom_range(0, nw - 1)
                                               : $urandom_range(0, 127));
          sent++;
        end else begin
          send_cmd(3'($urandom_range(6, 7)), $urandom_range(0, 63),
                   $urandom_range(0, 127), 16'($urandom));
        end
      end
    end
  endtask

  // Result side: random stalls between transfers.
  initial begin
    int n;
    bit seen;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = out_stall_on ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      seen = 1'b0;
      while (!seen) begin
        @(negedge clk_i);
        seen = out_valid_o;
        @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest pending read; valid and
  // ready are sampled in mid cycle, ahead of the edge that completes it.
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (read_results.size() == 0) begin
        $error("unexpected result transfer, out_coordinate %0d", out_item_o.out_coordinate);
        errors++;
      end else begin
        want = read_results.pop_front();
        if (out_item_o.out_coordinate !== want.out_coordinate) begin
          $error("out_coordinate expected %0d actual %0d",
                 want.out_coordinate, out_item_o.out_coordinate);
          errors++;
        end
        if (out_item_o.out_value !== want.out_value) begin
          $error("out_value expected %0d actual %0d",
                 $signed(want.out_value), $signed(out_item_o.out_value));
          errors++;
        end
        if (out_item_o.saturated_flag !== want.saturated_flag) begin
          $error("saturated_flag expected %0d actual %0d",
                 want.saturated_flag, out_item_o.saturated_flag);
          errors++;
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    longint unsigned den;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      den = (64'd1 << 31) + exp_series((64'(i) << 34) / SIG_ENTRIES);
      sig_pts[i] = longint'(((64'd1 << 47) + (den >> 1)) / den);
    end
    foreach (out_acc[c]) out_acc[c] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reads_after_reset();
    test_extremes();
    test_full_layer();
    test_random(1000);
    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
